// File: rtl/mciir_pkg.sv
// ----------------------------------------------------------------------------
// mciir_pkg
// Shared types, register map and defaults for the multichannel IIR filter.
// ----------------------------------------------------------------------------
package mciir_pkg;

    localparam int DEFAULT_CHANNELS  = 32;
    localparam int DEFAULT_MAX_ORDER = 2;

    localparam int DATA_W   = 32;  // Q16.16 samples
    localparam int COEF_W   = 32;  // Q2.29 coefficients
    localparam int COEF_FRAC = 29;
    localparam int CH_W     = 5;   // channel field
    localparam int ORDER_W  = 2;
    localparam int TDATA_W  = 40;  // channel + sample, padded to bytes
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    localparam logic [ORDER_W-1:0]       RST_ORDER = 2'd1;
    localparam logic signed [COEF_W-1:0] RST_B0    = 32'sd65566574;
    localparam logic signed [COEF_W-1:0] RST_B1    = 32'sd65566574;
    localparam logic signed [COEF_W-1:0] RST_B2    = 32'sd0;
    localparam logic signed [COEF_W-1:0] RST_A1    = -32'sd405737765;
    localparam logic signed [COEF_W-1:0] RST_A2    = 32'sd0;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_ORDER = 3'd0,
        REG_B0    = 3'd1,
        REG_B1    = 3'd2,
        REG_B2    = 3'd3,
        REG_A1    = 3'd4,
        REG_A2    = 3'd5
    } mciir_reg_t;

    typedef struct packed {
        logic [ORDER_W-1:0]       order;
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } mciir_cfg_t;

endpackage

// File: rtl/mciir_ram.sv
// ----------------------------------------------------------------------------
// mciir_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mciir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/mciir_regs.sv
// ----------------------------------------------------------------------------
// mciir_regs
// APB register file holding the filter order and the five coefficients.
// ----------------------------------------------------------------------------
module mciir_regs
    import mciir_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output mciir_cfg_t        cfg
);

    mciir_cfg_t cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_AW-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.order <= RST_ORDER;
            cfg_reg.b0    <= RST_B0;
            cfg_reg.b1    <= RST_B1;
            cfg_reg.b2    <= RST_B2;
            cfg_reg.a1    <= RST_A1;
            cfg_reg.a2    <= RST_A2;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ORDER: cfg_reg.order <= pwdata[ORDER_W-1:0];
                REG_B0:    cfg_reg.b0    <= pwdata;
                REG_B1:    cfg_reg.b1    <= pwdata;
                REG_B2:    cfg_reg.b2    <= pwdata;
                REG_A1:    cfg_reg.a1    <= pwdata;
                REG_A2:    cfg_reg.a2    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ORDER: prdata = APB_DW'(cfg_reg.order);
            REG_B0:    prdata = cfg_reg.b0;
            REG_B1:    prdata = cfg_reg.b1;
            REG_B2:    prdata = cfg_reg.b2;
            REG_A1:    prdata = cfg_reg.a1;
            REG_A2:    prdata = cfg_reg.a2;
            default:   prdata = '0;
        endcase
    end

endmodule

// File: rtl/multichannel_iir_filter.sv
// ----------------------------------------------------------------------------
// multichannel_iir_filter
// Direct form I IIR bank (order 1 or 2), one delay line pair per channel.
//
//  port group | dir | payload (low bit first)            | handshake
//  s_         | in  | channel[4:0], sample_in[36:5]      | tvalid/tready
//  m_         | out | channel_out[4:0], sample_out[36:5] | tvalid/tready
//  APB        | in  | filter order, b0, b1, b2, a1, a2   | psel/penable
//
//  Three register stages: history read, products, sum/round/saturate.
//  One request per cycle while m_ is not stalled and each channel differs
//  from the two before it; a channel still in the pipe stalls s_tready, so
//  a repeat of the same channel waits for history write-back before the re-read.
//  Reset is synchronous; it clears the pipe and the per-channel valid bits,
//  so no clearing pass runs. A stall on m_ holds the whole pipe.
// ----------------------------------------------------------------------------
module multichannel_iir_filter
    import mciir_pkg::*;
#(
    parameter int CHANNELS  = DEFAULT_CHANNELS,
    parameter int MAX_ORDER = DEFAULT_MAX_ORDER
) (
    input  logic               aclk,
    input  logic               aresetn,
    // channel[4:0], sample_in[36:5], zero pad [39:37]
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,
    // channel_out[4:0], sample_out[36:5], zero pad [39:37]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HIST_W   = MAX_ORDER * DATA_W;
    localparam int ROW_W    = 2 * HIST_W;
    localparam bit HAS_TAP2 = (MAX_ORDER >= 2);
    localparam int TAP2_IDX = HAS_TAP2 ? 1 : 0;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int SUM_W    = PROD_W + 3;
    localparam int Q_W      = SUM_W - COEF_FRAC;

    mciir_cfg_t cfg;

    mciir_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------- input side ----------------
    logic [CH_W-1:0]          s_ch;
    logic signed [DATA_W-1:0] s_x;
    logic [CH_AW-1:0]         s_addr;
    logic                     s_inrange;
    logic                     s_accept;
    logic                     adv;
    logic                     hazard;

    assign s_ch      = s_tdata[CH_W-1:0];
    assign s_x       = s_tdata[CH_W +: DATA_W];
    assign s_addr    = CH_AW'(s_ch);
    assign s_inrange = (32'(s_ch) < 32'(CHANNELS));

    // stage 1: history row arriving from RAM
    logic                     st1_valid_reg;
    logic                     st1_inrange_reg;
    logic                     st1_rowv_reg;
    logic [CH_W-1:0]          st1_ch_reg;
    logic [CH_AW-1:0]         st1_addr_reg;
    logic signed [DATA_W-1:0] st1_x_reg;

    // stage 2: products
    logic                     st2_valid_reg;
    logic                     st2_inrange_reg;
    logic [CH_W-1:0]          st2_ch_reg;
    logic [CH_AW-1:0]         st2_addr_reg;
    logic signed [DATA_W-1:0] st2_x_reg;
    logic [HIST_W-1:0]        st2_hin_reg;
    logic [HIST_W-1:0]        st2_hout_reg;
    logic signed [PROD_W-1:0] st2_p0_reg, st2_p1_reg, st2_p2_reg, st2_p3_reg, st2_p4_reg;

    // output register
    logic                     m_valid_reg;
    logic [CH_W-1:0]          m_ch_reg;
    logic signed [DATA_W-1:0] m_y_reg;

    logic [CHANNELS-1:0]      row_valid_reg;

    // pipe moves whenever the output register is free or being drained
    assign adv    = !m_valid_reg || m_tready;
    // a channel already in flight has not written its history back yet
    assign hazard = s_inrange &&
                    ((st1_valid_reg && st1_inrange_reg && st1_addr_reg == s_addr) ||
                     (st2_valid_reg && st2_inrange_reg && st2_addr_reg == s_addr));
    assign s_tready = adv && !hazard;
    assign s_accept = s_tvalid && s_tready;

    // ---------------- history RAM ----------------
    logic             ram_we;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;

    mciir_ram #(
        .WIDTH (ROW_W),
        .DEPTH (CHANNELS),
        .AW    (CH_AW)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (st2_addr_reg),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (s_addr),
        .rdata (ram_rdata)
    );

    // ---------------- stage 1 logic ----------------
    logic [HIST_W-1:0]        st1_hin;
    logic [HIST_W-1:0]        st1_hout;
    logic                     use_tap2;
    logic signed [DATA_W-1:0] x1, x2, y1, y2;

    assign st1_hin  = st1_rowv_reg ? ram_rdata[HIST_W-1:0]  : '0;
    assign st1_hout = st1_rowv_reg ? ram_rdata[ROW_W-1:HIST_W] : '0;
    // order codes 2 and 3 select second order
    assign use_tap2 = HAS_TAP2 && cfg.order[1];
    assign x1 = st1_hin[DATA_W-1:0];
    assign y1 = st1_hout[DATA_W-1:0];
    assign x2 = use_tap2 ? st1_hin[TAP2_IDX*DATA_W +: DATA_W]  : '0;
    assign y2 = use_tap2 ? st1_hout[TAP2_IDX*DATA_W +: DATA_W] : '0;

    // ---------------- stage 2 logic ----------------
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  rnd;
    logic signed [Q_W-1:0]    q;
    logic signed [DATA_W-1:0] y_sat;
    logic signed [DATA_W-1:0] y;
    logic                     ovf;

    always_comb begin
        sum = SUM_W'(st2_p0_reg) + SUM_W'(st2_p1_reg) + SUM_W'(st2_p2_reg)
            - SUM_W'(st2_p3_reg) - SUM_W'(st2_p4_reg);
        // round half up to Q16.16
        rnd = sum + (SUM_W'(1) <<< (COEF_FRAC - 1));
        q   = Q_W'(rnd >>> COEF_FRAC);
        ovf = (q[Q_W-1:DATA_W-1] != '0) && (q[Q_W-1:DATA_W-1] != '1);
        if (ovf) begin
            y_sat = q[Q_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            y_sat = q[DATA_W-1:0];
        end
        y = st2_inrange_reg ? y_sat : '0;
    end

    assign ram_we    = adv && st2_valid_reg && st2_inrange_reg;
    assign ram_wdata = {HIST_W'({st2_hout_reg, y}), HIST_W'({st2_hin_reg, st2_x_reg})};

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            row_valid_reg <= '0;
        end else if (adv) begin
            st1_valid_reg <= s_accept;
            st2_valid_reg <= st1_valid_reg;
            m_valid_reg   <= st2_valid_reg;
            if (ram_we) begin
                row_valid_reg[st2_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_ch_reg      <= s_ch;
            st1_addr_reg    <= s_addr;
            st1_x_reg       <= s_x;
            st1_inrange_reg <= s_inrange;
            st1_rowv_reg    <= s_inrange && row_valid_reg[s_addr];
        end
        if (adv) begin
            st2_ch_reg      <= st1_ch_reg;
            st2_addr_reg    <= st1_addr_reg;
            st2_x_reg       <= st1_x_reg;
            st2_inrange_reg <= st1_inrange_reg;
            st2_hin_reg     <= st1_hin;
            st2_hout_reg    <= st1_hout;
            st2_p0_reg      <= PROD_W'(cfg.b0 * st1_x_reg);
            st2_p1_reg      <= PROD_W'(cfg.b1 * x1);
            st2_p2_reg      <= PROD_W'(cfg.b2 * x2);
            st2_p3_reg      <= PROD_W'(cfg.a1 * y1);
            st2_p4_reg      <= PROD_W'(cfg.a2 * y2);
            m_ch_reg        <= st2_ch_reg;
            m_y_reg         <= y;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'({m_y_reg, m_ch_reg});

    // ---------------- assertions ----------------
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we && s_accept |-> st2_addr_reg != s_addr)
        else $error("history read and write hit the same row");

    a_one_per_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg && st1_inrange_reg && st2_valid_reg && st2_inrange_reg
        |-> st1_addr_reg != st2_addr_reg)
        else $error("same channel twice in the pipe");

    a_stall_holds_products: assert property (@(posedge aclk) disable iff (!aresetn)
        st2_valid_reg && !adv |=> st2_valid_reg && $stable(st2_p0_reg) && $stable(y))
        else $error("stage 2 changed during output stall");

    a_row_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> row_valid_reg[$past(st2_addr_reg)])
        else $error("written history row not marked valid");

endmodule
